// ----- src/rcfh_pkg.sv -----
// package for the ray versus cube face hit test: cube table, widths, sequencer states
package rcfh_pkg;

  localparam int CoordWidth = 24;
  localparam int FracBits = 16;
  localparam int TriCount = 12;
  localparam int TriIdxWidth = 4;
  // quotient width of the rounding divider
  localparam int QuotWidth = 48;
  // dividend |dir*num| stays below 2^23 * 2^(FracBits+15)
  localparam int DividendWidth = 56;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    logic signed [1:0] ax, ay, az;
    logic signed [1:0] nx, ny, nz;
    logic signed [2:0] e0x, e0y, e0z;
    logic signed [2:0] e1x, e1y, e1z;
  } tri_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_NEXT_AXIS,
    ST_BARY,
    ST_CHECK,
    ST_NEXT_TRI,
    ST_DONE
  } state_t;

  // corner a, normal n = cross(c-a, b-a), edges e0 = c-a, e1 = b-a
  function automatic tri_t tri_info(input logic [TriIdxWidth-1:0] idx);
    logic signed [1:0] c [3][3];
    tri_t r;
    begin
      c = '{'{2'sd0, 2'sd0, 2'sd0}, '{2'sd0, 2'sd0, 2'sd0}, '{2'sd0, 2'sd0, 2'sd0}};
      case (idx)
        4'd0: c = '{'{-2'sd1,-2'sd1, 2'sd1}, '{ 2'sd1,-2'sd1, 2'sd1}, '{ 2'sd1, 2'sd1, 2'sd1}};
        4'd1: c = '{'{ 2'sd1, 2'sd1, 2'sd1}, '{-2'sd1, 2'sd1, 2'sd1}, '{-2'sd1,-2'sd1, 2'sd1}};
        4'd2: c = '{'{ 2'sd1,-2'sd1,-2'sd1}, '{-2'sd1,-2'sd1,-2'sd1}, '{-2'sd1, 2'sd1,-2'sd1}};
        4'd3: c = '{'{-2'sd1, 2'sd1,-2'sd1}, '{ 2'sd1, 2'sd1,-2'sd1}, '{ 2'sd1,-2'sd1,-2'sd1}};
        4'd4: c = '{'{-2'sd1, 2'sd1, 2'sd1}, '{ 2'sd1, 2'sd1, 2'sd1}, '{ 2'sd1, 2'sd1,-2'sd1}};
        4'd5: c = '{'{ 2'sd1, 2'sd1,-2'sd1}, '{-2'sd1, 2'sd1,-2'sd1}, '{-2'sd1, 2'sd1, 2'sd1}};
        4'd6: c = '{'{-2'sd1,-2'sd1,-2'sd1}, '{ 2'sd1,-2'sd1,-2'sd1}, '{ 2'sd1,-2'sd1, 2'sd1}};
        4'd7: c = '{'{ 2'sd1,-2'sd1, 2'sd1}, '{-2'sd1,-2'sd1, 2'sd1}, '{-2'sd1,-2'sd1,-2'sd1}};
        4'd8: c = '{'{ 2'sd1,-2'sd1, 2'sd1}, '{ 2'sd1,-2'sd1,-2'sd1}, '{ 2'sd1, 2'sd1,-2'sd1}};
        4'd9: c = '{'{ 2'sd1, 2'sd1,-2'sd1}, '{ 2'sd1, 2'sd1, 2'sd1}, '{ 2'sd1,-2'sd1, 2'sd1}};
        4'd10: c = '{'{-2'sd1,-2'sd1,-2'sd1}, '{-2'sd1,-2'sd1, 2'sd1}, '{-2'sd1, 2'sd1, 2'sd1}};
        4'd11: c = '{'{-2'sd1, 2'sd1, 2'sd1}, '{-2'sd1, 2'sd1,-2'sd1}, '{-2'sd1,-2'sd1,-2'sd1}};
        default: ;
      endcase
      r.ax = c[0][0];
      r.ay = c[0][1];
      r.az = c[0][2];
      r.e0x = 3'(c[2][0]) - 3'(c[0][0]);
      r.e0y = 3'(c[2][1]) - 3'(c[0][1]);
      r.e0z = 3'(c[2][2]) - 3'(c[0][2]);
      r.e1x = 3'(c[1][0]) - 3'(c[0][0]);
      r.e1y = 3'(c[1][1]) - 3'(c[0][1]);
      r.e1z = 3'(c[1][2]) - 3'(c[0][2]);
      // cube normals are unit axis vectors scaled by 4; store sign of each
      r.nx = 2'((r.e0y * r.e1z - r.e0z * r.e1y) / 4);
      r.ny = 2'((r.e0z * r.e1x - r.e0x * r.e1z) / 4);
      r.nz = 2'((r.e0x * r.e1y - r.e0y * r.e1x) / 4);
      return r;
    end
  endfunction

endpackage

// ----- src/ray_cube_face_hit_test.sv -----
// top level of the ray versus cube face hit test
// One ray word in, one result word out. The 12 cube triangles are walked in order with a
// small sequencer; a triangle that does not face the ray is dropped after its setup state,
// one that does takes up to three passes of one shared restoring divider (48 quotient
// bits a pass). The result is held until out_ready takes it. in_ready is low while a
// ray is in work or its result waits to be taken.
module ray_cube_face_hit_test (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rcfh_pkg::coord_t origin_x,
  input  rcfh_pkg::coord_t origin_y,
  input  rcfh_pkg::coord_t origin_z,
  input  rcfh_pkg::coord_t dir_x,
  input  rcfh_pkg::coord_t dir_y,
  input  rcfh_pkg::coord_t dir_z,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output rcfh_pkg::coord_t point_x,
  output rcfh_pkg::coord_t point_y,
  output rcfh_pkg::coord_t point_z
);
  import rcfh_pkg::*;

  localparam logic signed [33:0] One = 34'sd1 <<< FracBits;
  localparam logic signed [33:0] Far = 34'sd4 <<< FracBits;

  state_t state, state_next;
  coord_t org [3];
  coord_t dir [3];
  logic [TriIdxWidth-1:0] tri_idx;
  logic [1:0] axis;
  logic signed [33:0] p [3];
  logic signed [33:0] den;
  logic signed [33:0] num;
  logic signed [36:0] u, v, bd;
  tri_t tr;

  logic div_start, div_busy;
  logic signed [DividendWidth-1:0] dividend;
  logic signed [QuotWidth:0] quotient;
  logic signed [QuotWidth+1:0] p_new;

  assign tr = tri_info(tri_idx);

  rcfh_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(dividend),
    .divisor(DividendWidth'(den)),
    .busy(div_busy),
    .quotient(quotient)
  );

  // den and num for the axis-aligned normal: one component only
  logic signed [33:0] den_c, num_c;
  always_comb begin
    if (tr.nx != 2'sd0) begin
      den_c = tr.nx[1] ? -34'(dir[0]) : 34'(dir[0]);
      num_c = (34'(tr.ax) * One) - 34'(org[0]);
      if (tr.nx[1]) num_c = -num_c;
    end else if (tr.ny != 2'sd0) begin
      den_c = tr.ny[1] ? -34'(dir[1]) : 34'(dir[1]);
      num_c = (34'(tr.ay) * One) - 34'(org[1]);
      if (tr.ny[1]) num_c = -num_c;
    end else begin
      den_c = tr.nz[1] ? -34'(dir[2]) : 34'(dir[2]);
      num_c = (34'(tr.az) * One) - 34'(org[2]);
      if (tr.nz[1]) num_c = -num_c;
    end
  end

  // scaled numerator for the current axis: dir * num; the normal length of 4 cancels
  // between num and den, and num fits 25 bits
  always_comb begin
    dividend = DividendWidth'($signed(dir[axis]) * $signed(num[24:0]));
    p_new = (QuotWidth+2)'(org[axis]) + (QuotWidth+2)'(quotient);
  end

  // barycentric terms; edges are short, so dot products stay narrow
  logic signed [36:0] w [3];
  logic signed [4:0] d00, d01, d11;
  logic signed [36:0] d02, d12;
  logic signed [36:0] u_c, v_c, bd_c;
  always_comb begin
    w[0] = 37'(p[0]) - 37'(tr.ax) * 37'(One);
    w[1] = 37'(p[1]) - 37'(tr.ay) * 37'(One);
    w[2] = 37'(p[2]) - 37'(tr.az) * 37'(One);
    d00 = 5'(tr.e0x * tr.e0x + tr.e0y * tr.e0y + tr.e0z * tr.e0z);
    d01 = 5'(tr.e0x * tr.e1x + tr.e0y * tr.e1y + tr.e0z * tr.e1z);
    d11 = 5'(tr.e1x * tr.e1x + tr.e1y * tr.e1y + tr.e1z * tr.e1z);
    d02 = 37'(tr.e0x) * w[0] + 37'(tr.e0y) * w[1] + 37'(tr.e0z) * w[2];
    d12 = 37'(tr.e1x) * w[0] + 37'(tr.e1y) * w[1] + 37'(tr.e1z) * w[2];
    bd_c = 37'(d00) * 37'(d11) - 37'(d01) * 37'(d01);
    u_c = 37'(d11) * d02 - 37'(d01) * d12;
    v_c = 37'(d00) * d12 - 37'(d01) * d02;
  end

  logic signed [44:0] lhs, rhs;
  logic is_far;
  assign lhs = 45'sd100 * (45'(u) + 45'(v));
  assign rhs = 45'sd101 * 45'(bd) * 45'(One);
  assign is_far = (p_new > Far) || (p_new < -Far);

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SETUP;
      ST_SETUP: begin
        if (den_c <= 0 || num_c < 0) state_next = ST_NEXT_TRI;
        else state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (!div_busy) state_next = ST_NEXT_AXIS;
      ST_NEXT_AXIS: begin
        if (is_far) state_next = ST_NEXT_TRI;
        else if (axis == 2'd2) state_next = ST_BARY;
        else state_next = ST_DIV_START;
      end
      ST_BARY: state_next = ST_CHECK;
      ST_CHECK: begin
        if (bd <= 0 || u < 0 || v < 0 || lhs > rhs) state_next = ST_NEXT_TRI;
        else state_next = ST_DONE;
      end
      ST_NEXT_TRI: begin
        if (tri_idx == TriIdxWidth'(TriCount - 1)) state_next = ST_DONE;
        else state_next = ST_SETUP;
      end
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        org[0] <= origin_x;
        org[1] <= origin_y;
        org[2] <= origin_z;
        dir[0] <= dir_x;
        dir[1] <= dir_y;
        dir[2] <= dir_z;
        tri_idx <= '0;
        hit <= 1'b0;
        point_x <= '0;
        point_y <= '0;
        point_z <= '0;
      end
      ST_SETUP: begin
        den <= den_c;
        num <= num_c;
        axis <= 2'd0;
      end
      ST_NEXT_AXIS: begin
        p[axis] <= 34'(p_new);
        axis <= axis + 2'd1;
      end
      ST_BARY: begin
        u <= u_c;
        v <= v_c;
        bd <= bd_c;
      end
      ST_CHECK: begin
        if (!(bd <= 0 || u < 0 || v < 0 || lhs > rhs)) begin
          hit <= 1'b1;
          point_x <= sat(p[0]);
          point_y <= sat(p[1]);
          point_z <= sat(p[2]);
        end
      end
      ST_NEXT_TRI: tri_idx <= tri_idx + 1'b1;
      default: ;
    endcase
  end

  function automatic coord_t sat(input logic signed [33:0] x);
    if (x > 34'sd8388607) return coord_t'(24'sh7FFFFF);
    else if (x < -34'sd8388608) return coord_t'(24'sh800000);
    else return coord_t'(x[CoordWidth-1:0]);
  endfunction
endmodule

// ----- src/rcfh_div.sv -----
// shared restoring divider, one quotient bit per cycle, rounds half away from zero
module rcfh_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [rcfh_pkg::DividendWidth-1:0] dividend,
  input  logic [rcfh_pkg::DividendWidth-1:0] divisor,
  output logic busy,
  output logic signed [rcfh_pkg::QuotWidth:0] quotient
);
  import rcfh_pkg::*;

  localparam int CntWidth = $clog2(QuotWidth + 1);

  logic [DividendWidth:0] num;
  logic [DividendWidth+1:0] den2;
  logic [DividendWidth+1:0] rem;
  logic [QuotWidth-1:0] q;
  logic [CntWidth-1:0] cnt;
  logic neg;
  logic [DividendWidth+1:0] rem_shift;
  logic [DividendWidth+1:0] rem_sub;

  // next remainder candidate
  always_comb begin
    rem_shift = {rem[DividendWidth:0], num[DividendWidth]};
    rem_sub = rem_shift - den2;
  end

  // iterate on (2|a| + d) / (2d)
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CntWidth'(QuotWidth);
      neg <= dividend[DividendWidth-1];
      // 2|a| + d stays below 2^QuotWidth: move it to the top so every bit is used
      num <= ((dividend[DividendWidth-1] ? (DividendWidth+1)'(-dividend) << 1
                                         : (DividendWidth+1)'(dividend) << 1)
              + (DividendWidth+1)'(divisor)) << (DividendWidth + 1 - QuotWidth);
      den2 <= (DividendWidth+2)'(divisor) << 1;
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      if (rem_shift >= den2) begin
        rem <= rem_sub;
        q <= {q[QuotWidth-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        q <= {q[QuotWidth-2:0], 1'b0};
      end
      num <= num << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CntWidth'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // preshift so the top bits enter first: quotient takes the low QuotWidth bits
  assign quotient = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule
